>>> hdl/pvs_pkg.sv
// Shared types and constants of the plurality vote selector.
`default_nettype none
package pvs_pkg;

	localparam int VOTE_W     = 16;
	localparam int VALUE_W    = 15;
	localparam int OUT_CNT_W  = 11;
	localparam int FRAC_W     = 16;
	localparam int CERT_W     = 17;
	localparam int INDEX_W    = 24;
	localparam int STRIDE_W   = 8;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WEEK_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STRIDE = 2'd2;

	localparam logic [VALUE_W-1:0]  WEEK_LIMIT_RST    = 15'h7FFF;
	localparam logic [SAMPLE_W-1:0] BASE_OFFSET_RST   = 16'd0;
	localparam logic [STRIDE_W-1:0] SAMPLE_STRIDE_RST = 8'd5;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_OUTER,
		ST_INNER,
		ST_DIV,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic              busy;
		logic [CERT_W-1:0] quotient;
	} div_stat_t;

endpackage
`default_nettype wire

>>> hdl/pvs_vote_if.sv
// Vote input channel: valid/ready with one vote and its last flag.
`default_nettype none
interface pvs_vote_if;
	logic                             valid;
	logic                             ready;
	logic signed [pvs_pkg::VOTE_W-1:0] vote_value;
	logic                             last_vote;

	modport source(output valid, output vote_value, output last_vote, input ready);
	modport sink(input valid, input vote_value, input last_vote, output ready);
endinterface
`default_nettype wire

>>> hdl/pvs_result_if.sv
// Result output channel: valid/ready with the winner summary of one vote set.
`default_nettype none
interface pvs_result_if;
	logic                            valid;
	logic                            ready;
	logic [pvs_pkg::VALUE_W-1:0]     winner_value;
	logic [pvs_pkg::OUT_CNT_W-1:0]   winner_count;
	logic [pvs_pkg::OUT_CNT_W-1:0]   total_votes;
	logic [pvs_pkg::CERT_W-1:0]      certainty_q16;
	logic [pvs_pkg::INDEX_W-1:0]     best_index;
	logic                            range_error;

	modport source(output valid, output winner_value, output winner_count,
		output total_votes, output certainty_q16, output best_index,
		output range_error, input ready);
	modport sink(input valid, input winner_value, input winner_count,
		input total_votes, input certainty_q16, input best_index,
		input range_error, output ready);
endinterface
`default_nettype wire

>>> hdl/plurality_vote_selector.sv
// Plurality vote selector: stores a set of class votes and reports the most frequent one.
// Votes enter one per cycle while loading and valid ones (0..week_limit) are written into
// an on-chip store of MAX_VOTES entries; out-of-range votes only raise range_error and
// votes past a full store are dropped. The beat with last_vote closes the set and the
// block stops taking votes while it walks the store: for each of the n stored votes it
// rereads the whole store through a second memory port and counts matches, then a
// one-bit-per-cycle divider forms certainty_q16. Ties go to the value that appeared
// first. The result sits in an output register, so the next set loads while it waits;
// a second result waits until the first beat is taken.
`default_nettype none
module plurality_vote_selector #(
	parameter int MAX_VOTES = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pvs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pvs_pkg::CFG_DATA_W-1:0]       cfg_data,
	pvs_vote_if.sink                             vote_in,
	pvs_result_if.source                         result_out
);

	localparam int CW = $clog2(MAX_VOTES + 1);
	localparam int AW = (MAX_VOTES > 1) ? $clog2(MAX_VOTES) : 1;

	pvs_pkg::state_t state_q, state_d;

	logic [pvs_pkg::VALUE_W-1:0]  week_limit_q;
	logic [pvs_pkg::SAMPLE_W-1:0] base_offset_q;
	logic [pvs_pkg::STRIDE_W-1:0] sample_stride_q;

	logic [CW-1:0]               count_q;
	logic                        err_q;
	logic [CW-1:0]               i_q;
	logic [CW-1:0]               j_q;
	logic [CW-1:0]               n_q;
	logic                        cmp_s1;
	logic [pvs_pkg::VALUE_W-1:0] best_val_q;
	logic [CW-1:0]               best_cnt_q;

	logic                            res_valid_q;
	logic [pvs_pkg::VALUE_W-1:0]     res_value_q;
	logic [pvs_pkg::OUT_CNT_W-1:0]   res_count_q;
	logic [pvs_pkg::OUT_CNT_W-1:0]   res_total_q;
	logic [pvs_pkg::CERT_W-1:0]      res_cert_q;
	logic [pvs_pkg::INDEX_W-1:0]     res_index_q;
	logic                            res_err_q;

	logic                        in_acc;
	logic                        vote_ok;
	logic                        store_en;
	logic                        re_a;
	logic                        re_b;
	logic                        div_start;
	logic                        inner_done;
	logic                        res_load;
	logic [pvs_pkg::VALUE_W-1:0] rd_a;
	logic [pvs_pkg::VALUE_W-1:0] rd_b;
	pvs_pkg::div_stat_t          div_stat;

	assign in_acc     = vote_in.valid && vote_in.ready;
	assign vote_ok    = !vote_in.vote_value[pvs_pkg::VOTE_W-1]
		&& (vote_in.vote_value[pvs_pkg::VALUE_W-1:0] <= week_limit_q);
	assign store_en   = in_acc && vote_ok && (count_q < CW'(MAX_VOTES));
	assign inner_done = (j_q == count_q) && !cmp_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pvs_pkg::ST_LOAD: begin
				if (in_acc && vote_in.last_vote) begin
					state_d = pvs_pkg::ST_OUTER;
				end
			end
			pvs_pkg::ST_OUTER: begin
				state_d = (i_q == count_q) ? pvs_pkg::ST_DIV : pvs_pkg::ST_INNER;
			end
			pvs_pkg::ST_INNER: begin
				if (inner_done) begin
					state_d = pvs_pkg::ST_OUTER;
				end
			end
			pvs_pkg::ST_DIV: begin
				state_d = pvs_pkg::ST_WAIT;
			end
			pvs_pkg::ST_WAIT: begin
				if (!div_stat.busy && (!res_valid_q || result_out.ready)) begin
					state_d = pvs_pkg::ST_LOAD;
				end
			end
			default: state_d = pvs_pkg::ST_LOAD;
		endcase
	end

	// state outputs
	always_comb begin
		vote_in.ready = 1'b0;
		re_a          = 1'b0;
		re_b          = 1'b0;
		div_start     = 1'b0;
		res_load      = 1'b0;
		unique case (state_q)
			pvs_pkg::ST_LOAD:  vote_in.ready = 1'b1;
			pvs_pkg::ST_OUTER: re_a = (i_q != count_q);
			pvs_pkg::ST_INNER: re_b = (j_q != count_q);
			pvs_pkg::ST_DIV:   div_start = 1'b1;
			pvs_pkg::ST_WAIT:  res_load = !div_stat.busy && (!res_valid_q || result_out.ready);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvs_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			week_limit_q    <= pvs_pkg::WEEK_LIMIT_RST;
			base_offset_q   <= pvs_pkg::BASE_OFFSET_RST;
			sample_stride_q <= pvs_pkg::SAMPLE_STRIDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pvs_pkg::CFG_WEEK_LIMIT:    week_limit_q <= cfg_data[pvs_pkg::VALUE_W-1:0];
				pvs_pkg::CFG_BASE_OFFSET:   base_offset_q <= cfg_data[pvs_pkg::SAMPLE_W-1:0];
				pvs_pkg::CFG_SAMPLE_STRIDE: sample_stride_q <= cfg_data[pvs_pkg::STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			err_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			n_q        <= '0;
			cmp_s1     <= 1'b0;
			best_val_q <= '0;
			best_cnt_q <= '0;
		end else begin
			if (in_acc) begin
				err_q <= err_q | !vote_ok;
				if (store_en) begin
					count_q <= count_q + CW'(1);
				end
				if (vote_in.last_vote) begin
					i_q        <= '0;
					best_val_q <= '0;
					best_cnt_q <= '0;
				end
			end
			if (state_q == pvs_pkg::ST_OUTER) begin
				j_q    <= '0;
				n_q    <= '0;
				cmp_s1 <= 1'b0;
			end
			if (state_q == pvs_pkg::ST_INNER) begin
				// rd_a holds the candidate; rd_b is the registered read of the address issued in the previous cycle
				if (j_q != count_q) begin
					j_q    <= j_q + CW'(1);
					cmp_s1 <= 1'b1;
				end else begin
					cmp_s1 <= 1'b0;
				end
				if (cmp_s1 && (rd_b == rd_a)) begin
					n_q <= n_q + CW'(1);
				end
				if (inner_done) begin
					i_q <= i_q + CW'(1);
					if (n_q > best_cnt_q) begin
						best_cnt_q <= n_q;
						best_val_q <= rd_a;
					end
				end
			end
			if (res_load) begin
				count_q <= '0;
				err_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_value_q <= best_val_q;
			res_count_q <= pvs_pkg::OUT_CNT_W'(best_cnt_q);
			res_total_q <= pvs_pkg::OUT_CNT_W'(count_q);
			res_cert_q  <= (count_q == '0) ? '0 : div_stat.quotient;
			res_index_q <= pvs_pkg::INDEX_W'(base_offset_q)
				+ pvs_pkg::INDEX_W'(sample_stride_q) * pvs_pkg::INDEX_W'(best_val_q);
			res_err_q   <= err_q;
		end
	end

	pvs_vote_mem #(
		.DEPTH(MAX_VOTES),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (store_en),
		.waddr  (count_q[AW-1:0]),
		.wdata  (vote_in.vote_value[pvs_pkg::VALUE_W-1:0]),
		.re_a   (re_a),
		.raddr_a(i_q[AW-1:0]),
		.rdata_a(rd_a),
		.re_b   (re_b),
		.raddr_b(j_q[AW-1:0]),
		.rdata_b(rd_b)
	);

	pvs_divider #(
		.CW(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (best_cnt_q),
		.den   (count_q),
		.stat  (div_stat)
	);

	assign result_out.valid         = res_valid_q;
	assign result_out.winner_value  = res_value_q;
	assign result_out.winner_count  = res_count_q;
	assign result_out.total_votes   = res_total_q;
	assign result_out.certainty_q16 = res_cert_q;
	assign result_out.best_index    = res_index_q;
	assign result_out.range_error   = res_err_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_VOTES))
		else $error("stored vote count past store depth");

	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pvs_pkg::ST_LOAD) |-> (best_cnt_q <= count_q))
		else $error("winner count above set size during walk");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pvs_pkg::ST_INNER) |-> (j_q <= count_q && i_q < count_q))
		else $error("walk index past stored votes");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == pvs_pkg::ST_WAIT && !div_stat.busy))
		else $error("result loaded outside divider completion");

	a_cert_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_cert_q <= 17'h10000))
		else $error("certainty above one");

endmodule
`default_nettype wire

>>> hdl/pvs_vote_mem.sv
// Vote store: one write port, two registered read ports.
`default_nettype none
module pvs_vote_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [pvs_pkg::VALUE_W-1:0] wdata,
	input  logic                        re_a,
	input  logic [AW-1:0]               raddr_a,
	output logic [pvs_pkg::VALUE_W-1:0] rdata_a,
	input  logic                        re_b,
	input  logic [AW-1:0]               raddr_b,
	output logic [pvs_pkg::VALUE_W-1:0] rdata_b
);

	logic [pvs_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

>>> hdl/pvs_divider.sv
// Restoring divider, one quotient bit per cycle: (num << 16) / den.
`default_nettype none
module pvs_divider #(
	parameter int CW = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [CW-1:0]      num,
	input  logic [CW-1:0]      den,
	output pvs_pkg::div_stat_t stat
);

	localparam int NB = CW + pvs_pkg::FRAC_W;
	localparam int SW = $clog2(NB + 1);

	logic          busy_q;
	logic [SW-1:0] step_q;
	logic [CW:0]   rem_q;
	logic [CW-1:0] den_q;
	logic [NB-1:0] dvd_q;
	logic [CW:0]   rem_sh;
	logic          fits;

	assign rem_sh = {rem_q[CW-1:0], dvd_q[NB-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= SW'(NB);
		end else if (busy_q) begin
			step_q <= step_q - SW'(1);
			if (step_q == SW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, pvs_pkg::FRAC_W'(0)};
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			dvd_q <= {dvd_q[NB-2:0], fits};
		end
	end

	assign stat.busy     = busy_q;
	assign stat.quotient = dvd_q[pvs_pkg::CERT_W-1:0];

endmodule
`default_nettype wire
